// File: src/fmbq_pkg.sv
// Package for the front/middle/back queue: operation and status codes,
// the command that is broadcast to the row of cells, and default sizes.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package fmbq_pkg;

    localparam int FMBQ_DEPTH       = 64;
    localparam int FMBQ_VALUE_WIDTH = 32;

    // Fixed field widths of the stream beats.
    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell in the cycle a beat is accepted.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

// File: src/fmbq_cell.sv
// One storage cell of the queue row. It keeps its word, takes its left
// or right neighbor's word, or loads the new value, as the command says.
// Depends on fmbq_pkg.
`timescale 1ns / 1ps

module fmbq_cell
    import fmbq_pkg::*;
#(
    parameter int VALUE_WIDTH = FMBQ_VALUE_WIDTH,
    parameter int IDX_W       = 6,
    parameter int INDEX       = 0
)
(
    input  logic                   clk,
    input  logic                   load,
    input  cell_cmd_t              cmd,
    input  logic [IDX_W-1:0]       pos,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] pop_word
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   at_pos;
    logic                   after_pos;

    assign at_pos    = (pos == IDX_W'(INDEX));
    assign after_pos = (pos < IDX_W'(INDEX));

    always_comb
    begin
        value_next = value_reg;
        if (cmd.insert)
        begin
            if (after_pos)
            begin
                value_next = left_value;
            end
            else if (at_pos)
            begin
                value_next = new_value;
            end
        end
        else if (cmd.remove)
        begin
            if (at_pos || after_pos)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

    // Only the cell being removed puts its word on the reduction.
    assign pop_word = (cmd.remove && at_pos) ? value_reg : '0;

endmodule

// File: src/fmbq_pop_tree.sv
// Two-level OR reduction that collects the word of the removed cell.
// Group results are registered; the final OR feeds the output register.
// Depends on fmbq_pkg.
`timescale 1ns / 1ps

module fmbq_pop_tree
    import fmbq_pkg::*;
#(
    parameter int VALUE_WIDTH = FMBQ_VALUE_WIDTH,
    parameter int DEPTH       = FMBQ_DEPTH
)
(
    input  logic                   clk,
    input  logic                   load,
    input  logic [VALUE_WIDTH-1:0] words [DEPTH],
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int GROUP = 8;
    localparam int NG    = (DEPTH + GROUP - 1) / GROUP;

    logic [VALUE_WIDTH-1:0] part_reg  [NG];
    logic [VALUE_WIDTH-1:0] part_next [NG];

    for (genvar g = 0; g < NG; g++)
    begin : g_group
        always_comb
        begin
            part_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < DEPTH)
                begin
                    part_next[g] = part_next[g] | words[g * GROUP + j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                part_reg[g] <= part_next[g];
            end
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NG; g++)
        begin
            result = result | part_reg[g];
        end
    end

endmodule

// File: src/front_middle_back_queue.sv
// Top level of the front/middle/back queue: decoder, count, row of cells,
// pop reduction and output register.
// Depends on fmbq_pkg, fmbq_cell and fmbq_pop_tree.
//
// Usage: one operation per slave beat. s_tuser carries the operation code,
// s_tdata the value to push (ignored on pops). Every operation yields one
// master beat with the popped value, the status and the occupancy after the
// operation. A push to the middle goes to position count/2, a pop from the
// middle removes position (count-1)/2. A pop on an empty queue reports
// status 1; a push on a full queue is dropped with status 2. Unused codes
// leave the queue alone and report status 0.
//
// Throughput is one operation per cycle while the receiver keeps up: every
// cell shifts in parallel in the cycle the beat is accepted. From acceptance
// the result passes through the registered group stage of the pop reduction and
// the output register. When the receiver stalls, the result waits in the
// output register, one more result waits in the reduction stage, and then
// s_tready drops until m_tready returns. Reset empties the queue and clears
// both stages; cell contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module front_middle_back_queue
    import fmbq_pkg::*;
#(
    parameter int DEPTH       = FMBQ_DEPTH,
    parameter int VALUE_WIDTH = FMBQ_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] popped_value, [38:32] occupancy, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       pos_full;
    logic [IDX_W-1:0]       pos;
    logic                   accept;
    logic                   full;
    logic                   empty;
    op_t                    op;
    cell_cmd_t              cmd;
    status_t                status;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH-1:0] pop_words  [DEPTH];
    logic [VALUE_WIDTH-1:0] tree_result;

    logic                   s1_valid_reg;
    status_t                s1_status_reg;
    logic [OCC_W-1:0]       s1_occ_reg;
    logic                   s1_adv;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_value_reg;
    logic [OCC_W-1:0]       out_occ_reg;
    status_t                out_status_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign op        = op_t'(s_tuser);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign new_value = VALUE_WIDTH'(s_tdata);

    always_comb
    begin
        cmd      = '0;
        status   = ST_DONE;
        pos_full = '0;
        unique case (op) inside
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_PUSH_FULL;
                end
                else
                begin
                    cmd.insert = accept;
                end
                if (op == OP_PUSH_MIDDLE)
                begin
                    pos_full = count_reg >> 1;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    pos_full = count_reg;
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    cmd.remove = accept;
                end
                if (op == OP_POP_MIDDLE)
                begin
                    pos_full = (count_reg - CNT_W'(1)) >> 1;
                end
                else if (op == OP_POP_BACK)
                begin
                    pos_full = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // Unused codes leave the queue untouched.
            end
        endcase
    end

    assign pos = pos_full[IDX_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_left
            assign left_value = cell_value[i - 1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_right
            assign right_value = cell_value[i + 1];
        end

        fmbq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .load        (accept),
            .cmd         (cmd),
            .pos         (pos),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .pop_word    (pop_words[i])
        );
    end

    fmbq_pop_tree #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DEPTH       (DEPTH)
    ) u_pop_tree (
        .clk    (clk),
        .load   (accept),
        .words  (pop_words),
        .result (tree_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_occ_reg    <= OCC_W'(count_next);
        end
        if (s1_adv)
        begin
            out_value_reg  <= DATA_W'(tree_result);
            out_occ_reg    <= s1_occ_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_occ_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

endmodule
